// File: rtl/serial_motor_command_receiver_defines.svh
// assertion macros shared by the serial motor command receiver modules
`ifndef SERIAL_MOTOR_COMMAND_RECEIVER_DEFINES_SVH
`define SERIAL_MOTOR_COMMAND_RECEIVER_DEFINES_SVH

// condition must hold in the same cycle, sampled on clk, off during reset
`define SMCR_ASSERT_HOLDS(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smcr check failed");

// condition must hold in the cycle after the antecedent
`define SMCR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smcr check failed");

`endif

// File: rtl/smcr_pkg.sv
// shared types and constants of the serial motor command receiver
`default_nettype none

package smcr_pkg;

    // sizing
    localparam int MOTOR_COUNT_MAX = 4;
    localparam int MOTOR_COUNT_DEF = 4;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CFG_INDEX_W     = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_NODE_ADDRESS  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = CFG_INDEX_W'(1);

    // configuration reset values
    localparam logic [7:0] NODE_ADDRESS_RST  = 8'h20;
    localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd10;

    // protocol characters
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_D       = 8'h44;
    localparam logic [7:0] CH_R       = 8'h52;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;

    // full drive when the override switch is pressed
    localparam logic [7:0] DRIVE_OVERRIDE = 8'hFF;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_DRIVE = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_AT,
        CLS_DOLLAR,
        CLS_PERCENT,
        CLS_D,
        CLS_R,
        CLS_CR,
        CLS_LF
    } byte_class_t;

    // input request
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_byte;
        logic       switch_pressed;
        logic       power_fault;
    } in_item_t;

    // result request
    typedef struct packed {
        logic [7:0] drive_0;
        logic [7:0] drive_1;
        logic [7:0] drive_2;
        logic [7:0] drive_3;
        logic       link_ok;
        logic       line_busy;
        logic       frame_done;
    } out_item_t;

    // classified command between front and back
    typedef struct packed {
        opcode_t     kind;
        byte_class_t cls;
        logic [7:0]  value;
        logic        switch_pressed;
        logic        power_fault;
    } cmd_t;

    // configuration write
    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [7:0]             data;
    } cfg_req_t;

endpackage

`default_nettype wire

// File: rtl/serial_motor_command_receiver.sv
// Serial motor command receiver, top level.
//
// Input channel: present an item with push; it is taken at a clock edge where
// push is high and full is low. Opcode 0 feeds a received bus byte to the
// frame parser, 1 is a watchdog tick, 2 refreshes the motor drive bytes.
// Result channel: every item gives exactly one result. While empty is low the
// oldest result is on the result port; pop with empty low takes it.
// Configuration: cfg_valid with cfg_index and cfg_data writes node address
// (index 0) or timeout ticks (index 1); cfg_ready is always high. Write only
// while no item is in flight.
// The accepting edge writes the item into the front queue; the back end's state
// update then writes its result into the result queue, where it shows.
// One item per cycle is sustained while the result queue has room; the back
// end updates its state as it takes each command.
// When pop is held low the result queue fills, the back end holds, the front
// queue fills and full rises; no request is lost.
// Reset clears both queues, all frame and watchdog state, the command and
// drive bytes, and loads node address 0x20 and timeout 10.
`default_nettype none

module serial_motor_command_receiver #(
    parameter int MOTOR_COUNT = smcr_pkg::MOTOR_COUNT_DEF,
    parameter int QUEUE_DEPTH = smcr_pkg::QUEUE_DEPTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire smcr_pkg::in_item_t              item,
    input  wire logic                            push,
    output logic                                 full,
    output smcr_pkg::out_item_t                  result,
    input  wire logic                            pop,
    output logic                                 empty,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [smcr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                      cfg_data
);

    smcr_pkg::cmd_t      cmd;
    smcr_pkg::out_item_t res;
    smcr_pkg::cfg_req_t  cfg;
    logic                cmd_valid;
    logic                cmd_take;
    logic                res_push;
    logic                res_full;

    // configuration request
    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid && cfg_ready;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // front end
    smcr_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .push      (push),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // back end
    smcr_back #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    // result queue
    smcr_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .data_t (smcr_pkg::out_item_t)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

`default_nettype wire

// File: rtl/smcr_queue.sv
// small first-in first-out queue with push/full and pop/empty sides
`default_nettype none
`include "serial_motor_command_receiver_defines.svh"

module smcr_queue #(
    parameter int  DEPTH  = smcr_pkg::QUEUE_DEPTH,
    parameter type data_t = smcr_pkg::cmd_t
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire data_t wdata,
    output logic       full,
    input  wire logic  pop,
    output data_t      rdata,
    output logic       empty
);

    // depth of two or more
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    data_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    // status
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // checks
    `SMCR_ASSERT_HOLDS(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))
    `SMCR_ASSERT_NEXT(a_push_grows, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1)
    `SMCR_ASSERT_NEXT(a_pop_shrinks, do_pop && !do_push, count_reg == $past(count_reg) - 1'b1)

endmodule

`default_nettype wire

// File: rtl/smcr_front.sv
// front end: accepts input requests, classifies them and queues commands
`default_nettype none

module smcr_front #(
    parameter int QUEUE_DEPTH = smcr_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire smcr_pkg::in_item_t item,
    input  wire logic             push,
    output logic                  full,
    output logic                  cmd_valid,
    output smcr_pkg::cmd_t        cmd,
    input  wire logic             cmd_take
);

    smcr_pkg::cmd_t        cmd_in;
    smcr_pkg::byte_class_t cls;
    logic                  cmd_empty;

    // byte classification
    always_comb
    begin
        unique case (item.rx_byte)
            smcr_pkg::CH_AT:      cls = smcr_pkg::CLS_AT;
            smcr_pkg::CH_DOLLAR:  cls = smcr_pkg::CLS_DOLLAR;
            smcr_pkg::CH_PERCENT: cls = smcr_pkg::CLS_PERCENT;
            smcr_pkg::CH_D:       cls = smcr_pkg::CLS_D;
            smcr_pkg::CH_R:       cls = smcr_pkg::CLS_R;
            smcr_pkg::CH_CR:      cls = smcr_pkg::CLS_CR;
            smcr_pkg::CH_LF:      cls = smcr_pkg::CLS_LF;
            default:              cls = smcr_pkg::CLS_OTHER;
        endcase
    end

    // command build
    always_comb
    begin
        cmd_in.kind           = smcr_pkg::opcode_t'(item.opcode);
        cmd_in.cls            = cls;
        cmd_in.value          = item.rx_byte;
        cmd_in.switch_pressed = item.switch_pressed;
        cmd_in.power_fault    = item.power_fault;
    end

    // decoupling queue toward the back end
    smcr_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .data_t (smcr_pkg::cmd_t)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_take),
        .rdata (cmd),
        .empty (cmd_empty)
    );

    assign cmd_valid = !cmd_empty;

endmodule

`default_nettype wire

// File: rtl/smcr_back.sv
// back end: frame parser, watchdog, drive update and configuration registers
`default_nettype none
`include "serial_motor_command_receiver_defines.svh"

module smcr_back #(
    parameter int MOTOR_COUNT = smcr_pkg::MOTOR_COUNT_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire smcr_pkg::cfg_req_t cfg,
    input  wire logic               cmd_valid,
    input  wire smcr_pkg::cmd_t     cmd,
    output logic                    cmd_take,
    input  wire logic               res_full,
    output logic                    res_push,
    output smcr_pkg::out_item_t     res
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ADDR = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        addr_armed_reg, addr_armed_next;
    logic [2:0]  idx_reg, idx_next;
    logic        start_armed_reg, start_armed_next;
    logic        end_armed_reg, end_armed_next;
    logic        busy_reg, busy_next;
    logic [7:0]  tick_reg, tick_next;
    logic        lamp_reg, lamp_next;
    logic [7:0]  node_reg;
    logic [7:0]  timeout_reg;
    logic [7:0]  hold_reg [3];
    logic        hold_we;
    logic [1:0]  hold_sel;
    logic [7:0]  cmd_reg [MOTOR_COUNT];
    logic [7:0]  cmd_next [MOTOR_COUNT];
    logic [7:0]  applied_reg [MOTOR_COUNT];
    logic [7:0]  applied_next [MOTOR_COUNT];
    logic        done;
    logic [7:0]  tick_inc;
    logic        header_ok;
    logic        tick_take;
    logic [smcr_pkg::MOTOR_COUNT_MAX-1:0][7:0] pay;
    logic [smcr_pkg::MOTOR_COUNT_MAX-1:0][7:0] drv;

    // one command per cycle while the result side has room
    assign cmd_take = cmd_valid && !res_full;
    assign res_push = cmd_take;
    assign tick_take = cmd_take && (cmd.kind == smcr_pkg::OP_TICK);

    // payload assembled from held bytes and the current byte
    assign pay      = {cmd.value, hold_reg[2], hold_reg[1], hold_reg[0]};
    assign tick_inc = tick_reg + 8'd1;
    assign hold_sel = 2'(idx_reg - 3'd3);
    assign header_ok = (idx_reg == 3'd0) ? (cmd.cls == smcr_pkg::CLS_D)
                                         : (cmd.cls == smcr_pkg::CLS_R);

    // command execution
    always_comb
    begin
        phase_next       = phase_reg;
        addr_armed_next  = addr_armed_reg;
        idx_next         = idx_reg;
        start_armed_next = start_armed_reg;
        end_armed_next   = end_armed_reg;
        busy_next        = busy_reg;
        tick_next        = tick_reg;
        lamp_next        = lamp_reg;
        hold_we          = 1'b0;
        done             = 1'b0;
        cmd_next         = cmd_reg;
        applied_next     = applied_reg;

        unique case (cmd.kind)
            smcr_pkg::OP_BYTE:
            begin
                // frame phase
                unique case (phase_reg)
                    PH_ADDR:
                    begin
                        if (addr_armed_reg)
                        begin
                            if (cmd.value == node_reg)
                            begin
                                phase_next = PH_DATA;
                                idx_next   = 3'd0;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                            end
                            addr_armed_next = 1'b0;
                        end
                        else if (cmd.cls == smcr_pkg::CLS_AT)
                        begin
                            addr_armed_next = 1'b1;
                        end
                    end
                    PH_DATA:
                    begin
                        hold_we = (idx_reg >= 3'd3) && (idx_reg <= 3'd5);
                        if (idx_reg < 3'd2)
                        begin
                            if (!header_ok)
                            begin
                                phase_next = PH_IDLE;
                                lamp_next  = 1'b0;
                            end
                        end
                        else if (idx_reg >= 3'd6)
                        begin
                            for (int i = 0; i < MOTOR_COUNT; i++)
                            begin
                                cmd_next[i] = pay[i];
                            end
                            phase_next = PH_IDLE;
                            tick_next  = 8'd0;
                            lamp_next  = 1'b1;
                            done       = 1'b1;
                        end
                        idx_next = idx_reg + 3'd1;
                    end
                    default:
                    begin
                    end
                endcase

                // start code
                if (start_armed_reg)
                begin
                    if (cmd.cls == smcr_pkg::CLS_DOLLAR)
                    begin
                        start_armed_next = 1'b0;
                        phase_next       = PH_ADDR;
                        idx_next         = 3'd0;
                        busy_next        = 1'b1;
                    end
                end
                else if (cmd.cls == smcr_pkg::CLS_PERCENT)
                begin
                    start_armed_next = 1'b1;
                end

                // end code
                if (end_armed_reg)
                begin
                    if (cmd.cls == smcr_pkg::CLS_LF)
                    begin
                        end_armed_next = 1'b0;
                        busy_next      = 1'b0;
                    end
                end
                else if (cmd.cls == smcr_pkg::CLS_CR)
                begin
                    end_armed_next = 1'b1;
                end
            end
            smcr_pkg::OP_TICK:
            begin
                // watchdog
                if (tick_inc > timeout_reg)
                begin
                    tick_next = 8'd0;
                    lamp_next = 1'b0;
                    for (int i = 0; i < MOTOR_COUNT; i++)
                    begin
                        cmd_next[i] = 8'd0;
                    end
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            smcr_pkg::OP_DRIVE:
            begin
                // override, power fault, then apply
                if (cmd.switch_pressed)
                begin
                    cmd_next[0] = smcr_pkg::DRIVE_OVERRIDE;
                end
                if (cmd.power_fault)
                begin
                    for (int i = 0; i < MOTOR_COUNT; i++)
                    begin
                        cmd_next[i] = 8'd0;
                    end
                end
                applied_next = cmd_next;
            end
            smcr_pkg::OP_NONE:
            begin
            end
        endcase
    end

    // result fields, absent motors read zero
    always_comb
    begin
        drv = '0;
        for (int i = 0; i < MOTOR_COUNT; i++)
        begin
            drv[i] = applied_next[i];
        end
        res.drive_0    = drv[0];
        res.drive_1    = drv[1];
        res.drive_2    = drv[2];
        res.drive_3    = drv[3];
        res.link_ok    = lamp_next;
        res.line_busy  = busy_next;
        res.frame_done = done;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            addr_armed_reg  <= 1'b0;
            idx_reg         <= 3'd0;
            start_armed_reg <= 1'b0;
            end_armed_reg   <= 1'b0;
            busy_reg        <= 1'b0;
            tick_reg        <= 8'd0;
            lamp_reg        <= 1'b0;
            for (int i = 0; i < MOTOR_COUNT; i++)
            begin
                cmd_reg[i]     <= 8'd0;
                applied_reg[i] <= 8'd0;
            end
        end
        else if (cmd_take)
        begin
            phase_reg       <= phase_next;
            addr_armed_reg  <= addr_armed_next;
            idx_reg         <= idx_next;
            start_armed_reg <= start_armed_next;
            end_armed_reg   <= end_armed_next;
            busy_reg        <= busy_next;
            tick_reg        <= tick_next;
            lamp_reg        <= lamp_next;
            cmd_reg         <= cmd_next;
            applied_reg     <= applied_next;
        end
    end

    // payload hold bytes, written before read within a frame
    always_ff @(posedge clk)
    begin
        if (cmd_take && hold_we)
        begin
            hold_reg[hold_sel] <= cmd.value;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_reg    <= smcr_pkg::NODE_ADDRESS_RST;
            timeout_reg <= smcr_pkg::TIMEOUT_TICKS_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                smcr_pkg::CFG_NODE_ADDRESS:  node_reg    <= cfg.data;
                smcr_pkg::CFG_TIMEOUT_TICKS: timeout_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // checks
    `SMCR_ASSERT_HOLDS(a_done_lamp, res_push && res.frame_done, res.link_ok)
    `SMCR_ASSERT_HOLDS(a_done_byte, res_push && res.frame_done, cmd.kind == smcr_pkg::OP_BYTE)
    `SMCR_ASSERT_NEXT(a_tick_bound, tick_take, tick_reg <= $past(timeout_reg))

endmodule

`default_nettype wire
